// ===== rtl/binary_min_heap_priority_queue_top_macros.svh =====
// Assertion macros for the heap queue RTL (used by bmhpq_ctrl).
// The macros expect clk_i and rst_ni in the scope where they are used.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define BMHPQ_ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define BMHPQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bmhpq_pkg.sv =====
// Package for the binary min-heap priority queue.
// Holds sizes, payload structs, codes, the sequencer state type and the key function.
package bmhpq_pkg;

  localparam int unsigned HEAP_DEPTH = 64;
  localparam int unsigned IDX_W      = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CHILD_W    = IDX_W + 1;
  localparam int unsigned COUNT_W    = 7;

  typedef enum logic [1:0] {
    KEY_ARRIVAL = 2'd0,
    KEY_BURST   = 2'd1,
    KEY_PRIO    = 2'd2,
    KEY_NONE    = 2'd3
  } key_sel_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_POP_RD,
    ST_DN_CHK,
    ST_DN_CMP,
    ST_RES
  } state_e;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    op_e         op;
    logic [7:0]  task_id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } in_t;

  typedef struct packed {
    logic               push_ok;
    logic               empty_res;
    logic [7:0]         out_id;
    logic [15:0]        out_arrival;
    logic [15:0]        out_burst;
    logic [7:0]         out_prio;
    logic [COUNT_W-1:0] count;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } mem_req_t;

  function automatic logic [15:0] entry_key(entry_t e, key_sel_e sel);
    case (sel)
      KEY_ARRIVAL: return e.arrival;
      KEY_BURST:   return e.burst;
      default:     return {8'd0, e.prio};
    endcase
  endfunction

endpackage

// ===== rtl/binary_min_heap_priority_queue_top.sv =====
// Binary min-heap priority queue of task entries: top level.
// Uses bmhpq_pkg, bmhpq_ctrl and bmhpq_ram; holds the key register and the output register.
//
// Usage:
//   in channel  : in_valid_i / in_stall_o / in_data_i. op selects push or pop.
//   out channel : out_valid_o / out_stall_i / out_data_o, one result per item,
//                 in order: push_ok, empty_res, popped entry and entry count.
//   cfg channel : cfg_valid_i / cfg_ready_o / cfg_data_i writes the ordering key
//                 (arrival, burst, priority, or three for no ordering). Write it
//                 only while no item is in flight.
//   Entries live in a one-write, two-read synchronous RAM; the sequencer walks
//   each heap level in a check state that issues the reads and a compare state
//   that writes back. One item is handled at a time: in_stall_o stays high
//   from acceptance until the result has passed to the output register.
//   While the receiver stalls, the output register holds its result and one
//   further item may be processed up to its result, then in_stall_o stays high.
//   Reset empties the heap (count 0) and selects arrival time as key; no RAM
//   clearing is needed since only slots below the count are read.
module binary_min_heap_priority_queue_top
  import bmhpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  key_sel_e key_sel_q;
  logic     out_valid_q, out_valid_d;
  out_t     out_q;
  logic     res_valid, res_ready;
  out_t     res;
  mem_req_t mem_req;
  entry_t   rdata_a, rdata_b;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_sel_q <= KEY_ARRIVAL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_sel_q <= key_sel_e'(cfg_data_i);
    end
  end

  bmhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_sel_i   (key_sel_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  bmhpq_ram #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_req.we),
    .waddr_i   (mem_req.waddr),
    .wdata_i   (mem_req.wdata),
    .raddr_a_i (mem_req.raddr_a),
    .raddr_b_i (mem_req.raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Output register takes a new result when empty or being drained this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/bmhpq_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// Standalone, no package dependency.
module bmhpq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 48
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_b_i,
  output logic [WIDTH-1:0]                 rdata_a_o,
  output logic [WIDTH-1:0]                 rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/bmhpq_ctrl.sv =====
// Heap sequencer: fill count, moving entry and sift-up / sift-down walk.
// Depends on bmhpq_pkg and the assertion macro header.
`include "binary_min_heap_priority_queue_top_macros.svh"

module bmhpq_ctrl
  import bmhpq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  key_sel_e key_sel_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_t      in_data_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output out_t     res_o,
  output mem_req_t mem_req_o,
  input  entry_t   rdata_a_i,
  input  entry_t   rdata_b_i
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  entry_t             mv_q, mv_d;
  entry_t             top_q, top_d;
  logic               push_ok_q, push_ok_d;
  logic               empty_q, empty_d;

  logic               ordered;
  logic               full;
  logic [IDX_W-1:0]   par_idx;
  logic [CHILD_W-1:0] left_w, right_w, fill_x;
  logic               has_left, has_right;
  logic [15:0]        key_mv, key_a, key_b, best_key;
  logic               go_left, go_right, up_swap;

  assign ordered   = (key_sel_i != KEY_NONE);
  assign full      = (fill_q == CNT_W'(HEAP_DEPTH));
  assign par_idx   = (cur_q - IDX_W'(1)) >> 1;
  assign left_w    = {cur_q, 1'b1};
  assign right_w   = left_w + CHILD_W'(1);
  assign fill_x    = CHILD_W'(fill_q);
  assign has_left  = (left_w < fill_x);
  assign has_right = (right_w < fill_x);

  assign key_mv   = entry_key(mv_q, key_sel_i);
  assign key_a    = entry_key(rdata_a_i, key_sel_i);
  assign key_b    = entry_key(rdata_b_i, key_sel_i);
  assign up_swap  = (key_mv < key_a);
  // Left child first, then right against the smaller of the two so far.
  assign go_left  = (key_mv > key_a);
  assign best_key = go_left ? key_a : key_mv;
  assign go_right = has_right && (best_key > key_b);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.op == OP_PUSH) begin
            state_d = full ? ST_RES : ST_UP_CHK;
          end else begin
            state_d = (fill_q == '0) ? ST_RES : ST_POP_RD;
          end
        end
      end
      ST_UP_CHK: state_d = (cur_q == '0 || !ordered) ? ST_RES : ST_UP_CMP;
      ST_UP_CMP: state_d = up_swap ? ST_UP_CHK : ST_RES;
      ST_POP_RD: state_d = ST_DN_CHK;
      ST_DN_CHK: state_d = (!ordered || !has_left) ? ST_RES : ST_DN_CMP;
      ST_DN_CMP: state_d = (go_left || go_right) ? ST_DN_CHK : ST_RES;
      ST_RES:    state_d = res_ready_i ? ST_IDLE : ST_RES;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Reads are issued one state ahead of their use; each write lands on the
  // current hole, which the following reads never address.
  always_comb begin
    fill_d    = fill_q;
    cur_d     = cur_q;
    mv_d      = mv_q;
    top_d     = top_q;
    push_ok_d = push_ok_q;
    empty_d   = empty_q;
    mem_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        mem_req_o.raddr_a = '0;
        mem_req_o.raddr_b = IDX_W'(fill_q - CNT_W'(1));
        if (in_valid_i) begin
          mv_d      = '{task_id: in_data_i.task_id, arrival: in_data_i.arrival,
                        burst: in_data_i.burst, prio: in_data_i.prio};
          top_d     = '0;
          push_ok_d = 1'b0;
          empty_d   = 1'b0;
          if (in_data_i.op == OP_PUSH) begin
            cur_d = IDX_W'(fill_q);
          end else if (fill_q == '0) begin
            empty_d = 1'b1;
          end else begin
            fill_d = fill_q - CNT_W'(1);
          end
        end
      end
      ST_UP_CHK: begin
        if (cur_q == '0 || !ordered) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cur_q;
          mem_req_o.wdata = mv_q;
          fill_d          = fill_q + CNT_W'(1);
          push_ok_d       = 1'b1;
        end else begin
          mem_req_o.raddr_a = par_idx;
        end
      end
      ST_UP_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cur_q;
        if (up_swap) begin
          mem_req_o.wdata = rdata_a_i;
          cur_d           = par_idx;
        end else begin
          mem_req_o.wdata = mv_q;
          fill_d          = fill_q + CNT_W'(1);
          push_ok_d       = 1'b1;
        end
      end
      ST_POP_RD: begin
        top_d = rdata_a_i;
        mv_d  = rdata_b_i;
        cur_d = '0;
      end
      ST_DN_CHK: begin
        if (!ordered || !has_left) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cur_q;
          mem_req_o.wdata = mv_q;
        end else begin
          mem_req_o.raddr_a = left_w[IDX_W-1:0];
          mem_req_o.raddr_b = right_w[IDX_W-1:0];
        end
      end
      ST_DN_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cur_q;
        if (go_right) begin
          mem_req_o.wdata = rdata_b_i;
          cur_d           = right_w[IDX_W-1:0];
        end else if (go_left) begin
          mem_req_o.wdata = rdata_a_i;
          cur_d           = left_w[IDX_W-1:0];
        end else begin
          mem_req_o.wdata = mv_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_RES);
  assign res_o       = '{push_ok: push_ok_q, empty_res: empty_q, out_id: top_q.task_id,
                         out_arrival: top_q.arrival, out_burst: top_q.burst,
                         out_prio: top_q.prio, count: COUNT_W'(fill_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    mv_q      <= mv_d;
    top_q     <= top_d;
    push_ok_q <= push_ok_d;
    empty_q   <= empty_d;
  end

  `BMHPQ_ASSERT_CLK(a_fill_bound, fill_q <= CNT_W'(HEAP_DEPTH), "fill count above depth")
  `BMHPQ_ASSERT_NEXT(a_full_refused, state_q == ST_IDLE && in_valid_i && in_data_i.op == OP_PUSH && full, state_q == ST_RES && !push_ok_q && $stable(fill_q), "push into full heap not refused")
  `BMHPQ_ASSERT_CLK(a_wr_in_range, !mem_req_o.we || CHILD_W'(mem_req_o.waddr) <= fill_x, "heap write beyond fill count")
  `BMHPQ_ASSERT_CLK(a_empty_res, !(res_valid_o && empty_q) || (fill_q == '0 && !push_ok_q), "empty result with entries held")

endmodule

// ===== bench/bmhpq_tb_pkg.sv =====
// Checking code for the heap priority queue bench: a tracker that mirrors the heap
// and holds the results still owed by the block. Depends on bmhpq_pkg only.
package bmhpq_tb_pkg;
  import bmhpq_pkg::*;

  class heap_queue_tracker;
    entry_t      slots[HEAP_DEPTH];
    int unsigned fill;
    key_sel_e    key_sel;
    out_t        owed_results[$];
    int unsigned mismatches;

    function new();
      fill = 0;
      key_sel = KEY_ARRIVAL;
      mismatches = 0;
    endfunction

    function void set_key(key_sel_e k);
      key_sel = k;
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    function logic [15:0] key_of(entry_t e);
      case (key_sel)
        KEY_ARRIVAL: return e.arrival;
        KEY_BURST:   return e.burst;
        default:     return {8'd0, e.prio};
      endcase
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      entry_t t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    // Work out the result of one accepted operation and queue it.
    function void apply_op(in_t item);
      out_t        res;
      entry_t      top;
      int unsigned cur;
      int unsigned par;
      int unsigned lft;
      int unsigned rgt;
      int unsigned best;
      res = '0;
      if (item.op == OP_PUSH) begin
        if (fill < HEAP_DEPTH) begin
          cur = fill;
          slots[cur] = '{task_id: item.task_id, arrival: item.arrival,
                         burst: item.burst, prio: item.prio};
          if (key_sel != KEY_NONE) begin
            while (cur > 0) begin
              par = (cur - 1) / 2;
              if (key_of(slots[cur]) < key_of(slots[par])) begin
                swap_slots(cur, par);
                cur = par;
              end else begin
                break;
              end
            end
          end
          fill++;
          res.push_ok = 1'b1;
        end
      end else if (fill == 0) begin
        res.empty_res = 1'b1;
      end else begin
        top = slots[0];
        fill--;
        slots[0] = slots[fill];
        cur = 0;
        if (key_sel != KEY_NONE) begin
          while (2 * cur + 1 < fill) begin
            lft = 2 * cur + 1;
            rgt = lft + 1;
            best = cur;
            if (key_of(slots[best]) > key_of(slots[lft])) best = lft;
            if (rgt < fill && key_of(slots[best]) > key_of(slots[rgt])) best = rgt;
            if (best == cur) break;
            swap_slots(cur, best);
            cur = best;
          end
        end
        res.out_id      = top.task_id;
        res.out_arrival = top.arrival;
        res.out_burst   = top.burst;
        res.out_prio    = top.prio;
      end
      res.count = COUNT_W'(fill);
      owed_results.push_back(res);
    endfunction

    // Compare one accepted result with the oldest owed one.
    function void compare_result(out_t got);
      out_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing owed: %p", got);
        return;
      end
      want = owed_results.pop_front();
      if (got.push_ok !== want.push_ok || got.empty_res !== want.empty_res ||
          got.out_id !== want.out_id || got.out_arrival !== want.out_arrival ||
          got.out_burst !== want.out_burst || got.out_prio !== want.out_prio ||
          got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected ok=%b empty=%b id=%h arr=%h burst=%h prio=%h cnt=%0d",
                   want.push_ok, want.empty_res, want.out_id, want.out_arrival,
                   want.out_burst, want.out_prio, want.count);
          $display("          actual   ok=%b empty=%b id=%h arr=%h burst=%h prio=%h cnt=%0d",
                   got.push_ok, got.empty_res, got.out_id, got.out_arrival,
                   got.out_burst, got.out_prio, got.count);
        end
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
// Top of the heap priority queue bench: clock, reset, drivers and the final verdict.
// Depends on bmhpq_pkg, bmhpq_tb_pkg and binary_min_heap_priority_queue_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bmhpq_pkg::*;
  import bmhpq_tb_pkg::*;

  localparam int unsigned PHASES    = 12;
  localparam int unsigned PHASE_OPS = 137;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_t        in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_t       out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i;

  heap_queue_tracker trk;
  bit                calm_phase;

  binary_min_heap_priority_queue_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none in a calm phase.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_phase || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_t mk_item(op_e op, logic [7:0] id, logic [15:0] arr,
                                  logic [15:0] bur, logic [7:0] pri);
    return '{op: op, task_id: id, arrival: arr, burst: bur, prio: pri};
  endfunction

  // Random entry; a share of narrow and extreme values forces key ties.
  function automatic in_t random_item(int unsigned push_pct);
    op_e         op;
    int unsigned style;
    in_t         item;
    op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    style = $urandom_range(0, 3);
    item = mk_item(op, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    if (style == 1) begin
      item.arrival = 16'($urandom_range(0, 3));
      item.burst   = 16'($urandom_range(0, 3));
      item.prio    = 8'($urandom_range(0, 3));
    end else if (style == 2) begin
      item.arrival = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      item.burst   = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      item.prio    = $urandom_range(0, 1) ? 8'hff : 8'h00;
    end
    return item;
  endfunction

  task automatic send_op(in_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and hold until every owed result has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (trk.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_key(key_sel_e k);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    trk.set_key(k);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) trk.apply_op(in_data_i);
      if (out_valid_o && !out_stall_i) trk.compare_result(out_data_o);
    end
  end

  initial begin
    int unsigned n_go;
    int unsigned n_hold;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n_go = $urandom_range(1, 12);
      repeat (n_go) begin
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      n_hold = pick_gap();
      repeat (n_hold) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
  end

  initial begin
    key_sel_e    plan[PHASES];
    int unsigned push_pct;
    trk = new();
    plan = '{KEY_ARRIVAL, KEY_PRIO, KEY_BURST, KEY_NONE, KEY_ARRIVAL, KEY_BURST,
             KEY_PRIO, KEY_NONE, KEY_BURST, KEY_ARRIVAL, KEY_PRIO, KEY_ARRIVAL};
    calm_phase  = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pop, extreme entries, a key tie, drain to empty again.
    send_op(mk_item(OP_POP, 8'h00, 16'h0000, 16'h0000, 8'h00));
    send_op(mk_item(OP_PUSH, 8'h00, 16'h0000, 16'h0000, 8'h00));
    send_op(mk_item(OP_PUSH, 8'hff, 16'hffff, 16'hffff, 8'hff));
    send_op(mk_item(OP_PUSH, 8'h5a, 16'h8000, 16'h0001, 8'h80));
    send_op(mk_item(OP_PUSH, 8'h3c, 16'h8000, 16'hffff, 8'h00));
    send_op(mk_item(OP_PUSH, 8'ha5, 16'h0001, 16'h7fff, 8'h7f));
    repeat (6) send_op(mk_item(OP_POP, 8'hff, 16'hffff, 16'hffff, 8'hff));
    wait_drained();
    write_key(KEY_PRIO);
    send_op(mk_item(OP_PUSH, 8'h11, 16'h0000, 16'hffff, 8'h02));
    send_op(mk_item(OP_PUSH, 8'h22, 16'hffff, 16'h0000, 8'h01));
    send_op(mk_item(OP_PUSH, 8'h33, 16'h1234, 16'h4321, 8'h01));
    repeat (4) send_op(mk_item(OP_POP, 8'h00, 16'h0000, 16'h0000, 8'h00));

    // Random phases: balanced, filling past full, and draining past empty.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_key(plan[ph]);
      calm_phase = (ph % 4 == 3);
      case (ph % 3)
        0: push_pct = 50;
        1: push_pct = 85;
        default: push_pct = 15;
      endcase
      for (int unsigned i = 0; i < PHASE_OPS; i++) send_op(random_item(push_pct));
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (trk.mismatches == 0 && trk.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
